// File: rtl/core/cbvb_pkg.sv
// ----------------------------------------------------------------------------
// cbvb_pkg
// Shared types, field widths, codes and helpers for the callback to vblank
// mapping solver.
// ----------------------------------------------------------------------------
package cbvb_pkg;

  localparam int TIME_W = 63;
  localparam int ORD_W  = 32;
  localparam int CFG_W  = 4;
  localparam int IDX_W  = 5;

  // input function codes
  localparam logic [1:0] FN_VBLANK   = 2'd0;
  localparam logic [1:0] FN_CALLBACK = 2'd1;
  localparam logic [1:0] FN_FINISH   = 2'd2;
  localparam logic [1:0] FN_NONE     = 2'd3;

  // solution classes, equal to the saturated count
  localparam logic [1:0] CLS_NONE   = 2'd0;
  localparam logic [1:0] CLS_UNIQUE = 2'd1;
  localparam logic [1:0] CLS_AMBIG  = 2'd2;

  localparam logic [CFG_W-1:0] SYNC_ONE = 4'd1;

  // summary of the loaded window
  typedef struct packed {
    logic              err;
    logic [ORD_W-1:0]  first_ord;
    logic [TIME_W-1:0] first_vt;
    logic [TIME_W-1:0] last_vt;
    logic [TIME_W-1:0] first_ct;
    logic [TIME_W-1:0] last_ct;
  } ld_info_t;

  // one result item
  typedef struct packed {
    logic             status;
    logic [1:0]       sclass;
    logic [1:0]       scount;
    logic [IDX_W-1:0] rec_idx;
    logic             cvalid;
    logic [ORD_W-1:0] cord;
    logic             avalid;
    logic [ORD_W-1:0] aord;
    logic             last;
  } result_t;

  // add two counts, saturating at two
  function automatic logic [1:0] sat2(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > 3'd2) ? CLS_AMBIG : s[1:0];
  endfunction

endpackage

// File: rtl/core/callback_to_vblank_mapping_solver_core.sv
// ----------------------------------------------------------------------------
// callback_to_vblank_mapping_solver_core
// Loads vblank samples and callback timestamps, then counts and reports the
// increasing maps of callbacks onto vblank intervals.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  in       | in_valid, in_stall, func, event_ordinal, | into block
//           | event_time                               |
//  out      | out_valid, out_stall, status, ...        | out of block
//  cfg      | cfg_valid, cfg_ready, cfg_data           | into block
//
// a load or unknown item gives one result item. a finish walks every table
// cell of R records by K intervals, and traces the map back as well when it
// is unique: every table cell passes through the single read port of its
// 2-bit count table.
// rst is synchronous; it clears the window, the error flag and sync_interval
// to one. in_stall is high while a finish is being solved or a result waits.
// ----------------------------------------------------------------------------
module callback_to_vblank_mapping_solver_core import cbvb_pkg::*; #(
  parameter int MAX_VBLANKS = 64,
  parameter int MAX_RECORDS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        func,
  input  logic [ORD_W-1:0]  event_ordinal,
  input  logic [TIME_W-1:0] event_time,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              status,
  output logic [1:0]        solution_class,
  output logic [1:0]        solution_count,
  output logic [IDX_W-1:0]  record_index,
  output logic              consensus_valid,
  output logic [ORD_W-1:0]  consensus_ordinal,
  output logic              assigned_valid,
  output logic [ORD_W-1:0]  assigned_ordinal,
  output logic              last_result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int OW  = $clog2(MAX_VBLANKS);
  localparam int VCW = $clog2(MAX_VBLANKS+1);
  localparam int CCW = $clog2(MAX_RECORDS+1);
  localparam int RIW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

  logic [CFG_W-1:0]  sync_interval;
  logic              slot_free;
  logic              accept;
  logic              ld;
  logic              busy;
  logic              emit;
  logic              err_next;
  ld_info_t          info;
  result_t           sol_res;
  result_t           ld_res;
  result_t           res;
  logic [VCW-1:0]    vcount;
  logic [CCW-1:0]    ccount;
  logic [OW-1:0]     vt_raddr;
  logic [RIW-1:0]    ct_raddr;
  logic [TIME_W-1:0] vt_rdata;
  logic [TIME_W-1:0] ct_rdata;

  // handshake
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = busy || !slot_free;
  assign accept    = in_valid && !in_stall;
  assign ld        = accept && ((func == FN_VBLANK) || (func == FN_CALLBACK));
  assign cfg_ready = 1'b1;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_interval <= SYNC_ONE;
    end else if (cfg_valid && cfg_ready) begin
      sync_interval <= cfg_data;
    end
  end

  cbvb_load #(
    .MAX_VBLANKS(MAX_VBLANKS),
    .MAX_RECORDS(MAX_RECORDS)
  ) u_load (
    .clk      (clk),
    .rst      (rst),
    .ld       (ld),
    .func     (func),
    .ord      (event_ordinal),
    .t        (event_time),
    .err_next (err_next),
    .info     (info),
    .vcount   (vcount),
    .ccount   (ccount),
    .vt_raddr (vt_raddr),
    .ct_raddr (ct_raddr),
    .vt_rdata (vt_rdata),
    .ct_rdata (ct_rdata)
  );

  cbvb_solver #(
    .MAX_VBLANKS(MAX_VBLANKS),
    .MAX_RECORDS(MAX_RECORDS)
  ) u_solver (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && (func == FN_FINISH)),
    .cfg_ok    (sync_interval == SYNC_ONE),
    .info      (info),
    .vcount    (vcount),
    .ccount    (ccount),
    .vt_raddr  (vt_raddr),
    .ct_raddr  (ct_raddr),
    .vt_rdata  (vt_rdata),
    .ct_rdata  (ct_rdata),
    .slot_free (slot_free),
    .busy      (busy),
    .emit      (emit),
    .res       (sol_res)
  );

  // load and unknown item result
  always_comb begin
    ld_res = '0;
    ld_res.status = (func == FN_NONE) ? 1'b1 : err_next;
    ld_res.last = 1'b1;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && func != FN_FINISH) || emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && func != FN_FINISH) begin
      res <= ld_res;
    end else if (emit) begin
      res <= sol_res;
    end
  end

  assign status            = res.status;
  assign solution_class    = res.sclass;
  assign solution_count    = res.scount;
  assign record_index      = res.rec_idx;
  assign consensus_valid   = res.cvalid;
  assign consensus_ordinal = res.cord;
  assign assigned_valid    = res.avalid;
  assign assigned_ordinal  = res.aord;
  assign last_result       = res.last;

endmodule

// File: rtl/core/cbvb_load.sv
// ----------------------------------------------------------------------------
// cbvb_load
// Order checks for vblank samples and callback timestamps, time stores and
// window summary.
// ----------------------------------------------------------------------------
module cbvb_load import cbvb_pkg::*; #(
  parameter int MAX_VBLANKS = 64,
  parameter int MAX_RECORDS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    ld,
  input  logic [1:0]                              func,
  input  logic [ORD_W-1:0]                        ord,
  input  logic [TIME_W-1:0]                       t,
  output logic                                    err_next,
  output ld_info_t                                info,
  output logic [$clog2(MAX_VBLANKS+1)-1:0]        vcount,
  output logic [$clog2(MAX_RECORDS+1)-1:0]        ccount,
  input  logic [$clog2(MAX_VBLANKS)-1:0]          vt_raddr,
  input  logic [((MAX_RECORDS>1)?$clog2(MAX_RECORDS):1)-1:0] ct_raddr,
  output logic [TIME_W-1:0]                       vt_rdata,
  output logic [TIME_W-1:0]                       ct_rdata
);

  localparam int OW  = $clog2(MAX_VBLANKS);
  localparam int VCW = $clog2(MAX_VBLANKS+1);
  localparam int CCW = $clog2(MAX_RECORDS+1);
  localparam int RIW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

  logic [TIME_W-1:0] vt_mem [MAX_VBLANKS];
  logic [TIME_W-1:0] ct_mem [MAX_RECORDS];
  logic [ORD_W-1:0]  last_ord;
  logic              v_store;
  logic              c_store;
  logic              v_bad;
  logic              c_bad;

  // item checks
  always_comb begin
    v_bad = 1'b0;
    c_bad = 1'b0;
    if (vcount >= VCW'(MAX_VBLANKS)) begin
      v_bad = 1'b1;
    end else if (vcount != '0) begin
      v_bad = (last_ord == '1) || (ord != last_ord + 32'd1) || (t <= info.last_vt);
    end
    c_bad = (ccount >= CCW'(MAX_RECORDS)) || ((ccount != '0) && (t <= info.last_ct));
    v_store = ld && !info.err && (func == FN_VBLANK) && !v_bad;
    c_store = ld && !info.err && (func == FN_CALLBACK) && !c_bad;
    err_next = info.err;
    if (ld && (func == FN_VBLANK) && v_bad) err_next = 1'b1;
    if (ld && (func == FN_CALLBACK) && c_bad) err_next = 1'b1;
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      info.err       <= 1'b0;
      info.first_ord <= '0;
      last_ord       <= '0;
      vcount         <= '0;
      ccount         <= '0;
    end else begin
      info.err <= err_next;
      if (v_store) begin
        if (vcount == '0) begin
          info.first_ord <= ord;
          info.first_vt  <= t;
        end
        info.last_vt <= t;
        last_ord     <= ord;
        vcount       <= vcount + VCW'(1);
      end
      if (c_store) begin
        if (ccount == '0) info.first_ct <= t;
        info.last_ct <= t;
        ccount       <= ccount + CCW'(1);
      end
    end
  end

  // time stores
  always_ff @(posedge clk) begin
    if (v_store) vt_mem[vcount[OW-1:0]] <= t;
    if (c_store) ct_mem[ccount[RIW-1:0]] <= t;
    vt_rdata <= vt_mem[vt_raddr];
    ct_rdata <= ct_mem[ct_raddr];
  end

endmodule

// File: rtl/core/cbvb_solver.sv
// ----------------------------------------------------------------------------
// cbvb_solver
// Sequencer that checks the window, finds each record's latest opportunity,
// fills the prefix and suffix count tables, traces a unique map and walks
// the consensus prefix, one table cell at a time.
// ----------------------------------------------------------------------------
module cbvb_solver import cbvb_pkg::*; #(
  parameter int MAX_VBLANKS = 64,
  parameter int MAX_RECORDS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic                                    cfg_ok,
  input  ld_info_t                                info,
  input  logic [$clog2(MAX_VBLANKS+1)-1:0]        vcount,
  input  logic [$clog2(MAX_RECORDS+1)-1:0]        ccount,
  output logic [$clog2(MAX_VBLANKS)-1:0]          vt_raddr,
  output logic [((MAX_RECORDS>1)?$clog2(MAX_RECORDS):1)-1:0] ct_raddr,
  input  logic [TIME_W-1:0]                       vt_rdata,
  input  logic [TIME_W-1:0]                       ct_rdata,
  input  logic                                    slot_free,
  output logic                                    busy,
  output logic                                    emit,
  output result_t                                 res
);

  localparam int OW    = $clog2(MAX_VBLANKS);
  localparam int VCW   = $clog2(MAX_VBLANKS+1);
  localparam int CCW   = $clog2(MAX_RECORDS+1);
  localparam int RIW   = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int AW    = CCW + OW;
  localparam int DEPTH = 1 << AW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_BAD   = 4'd2;
  localparam logic [3:0] S_LIM   = 4'd3;
  localparam logic [3:0] S_LIMC  = 4'd4;
  localparam logic [3:0] S_FRD   = 4'd5;
  localparam logic [3:0] S_FWR   = 4'd6;
  localparam logic [3:0] S_SRD   = 4'd7;
  localparam logic [3:0] S_SWR   = 4'd8;
  localparam logic [3:0] S_TRD1  = 4'd9;
  localparam logic [3:0] S_TRD2  = 4'd10;
  localparam logic [3:0] S_TRD3  = 4'd11;
  localparam logic [3:0] S_CRD   = 4'd12;
  localparam logic [3:0] S_CACC  = 4'd13;
  localparam logic [3:0] S_EMIT  = 4'd14;

  logic [3:0]     state;
  logic [CCW-1:0] r;
  logic [OW-1:0]  o;
  logic [OW-1:0]  kk;
  logic [1:0]     skip;
  logic [1:0]     cnt;
  logic [1:0]     feas;
  logic [OW-1:0]  cons;
  logic           chain;
  logic [1:0]     tb_skip;

  logic [OW-1:0]  lim [MAX_RECORDS];
  logic [OW-1:0]  asg [MAX_RECORDS];
  logic [1:0]     ptab [DEPTH];
  logic [1:0]     stab [DEPTH];
  logic [1:0]     pd;
  logic [1:0]     sd;

  logic [CCW-1:0] rm1, rp1;
  logic [OW-1:0]  om1, op1, km1;
  logic [AW-1:0]  p_raddr, s_raddr;
  logic [RIW-1:0] lim_idx;
  logic [OW-1:0]  lim_val;
  logic           bad_win;
  logic [1:0]     fwd_pv, fwd_sel, fwd_val;
  logic [1:0]     suf_sv, suf_sel, suf_val;
  logic [1:0]     tb_raw, tb_sel;
  logic           take;
  logic [1:0]     c_pv, c_sv;
  logic           hit;
  logic           chain_n;
  logic [VCW-1:0] vcm1;

  assign rm1  = r - CCW'(1);
  assign rp1  = r + CCW'(1);
  assign om1  = o - OW'(1);
  assign op1  = o + OW'(1);
  assign km1  = kk - OW'(1);
  assign vcm1 = vcount - VCW'(1);

  assign vt_raddr = op1;
  assign ct_raddr = r[RIW-1:0];
  assign busy     = (state != S_IDLE);

  // window check
  assign bad_win = info.err || !cfg_ok || (vcount < VCW'(2)) || (ccount == '0) ||
                   (info.first_ct < info.first_vt) || (info.last_ct >= info.last_vt);

  // table read addresses and limit select by phase
  always_comb begin
    p_raddr = '0;
    s_raddr = '0;
    lim_idx = '0;
    unique case (state)
      S_FRD:  p_raddr = {rm1, om1};
      S_FWR:  lim_idx = rm1[RIW-1:0];
      S_SRD:  s_raddr = {rp1, op1};
      S_SWR:  lim_idx = r[RIW-1:0];
      S_TRD1: p_raddr = {r, om1};
      S_TRD2: p_raddr = {rm1, om1};
      S_TRD3: lim_idx = rm1[RIW-1:0];
      S_CRD: begin
        p_raddr = {r, o};
        s_raddr = {rp1, op1};
      end
      S_CACC: lim_idx = r[RIW-1:0];
      default: begin
        p_raddr = '0;
      end
    endcase
  end

  assign lim_val = lim[lim_idx];

  // cell arithmetic for each phase
  always_comb begin
    fwd_pv  = (rm1 == '0) ? 2'd1 : ((om1 == '0) ? 2'd0 : pd);
    fwd_sel = (om1 <= lim_val) ? fwd_pv : 2'd0;
    fwd_val = sat2(skip, fwd_sel);
    suf_sv  = (rp1 == ccount) ? 2'd1 : ((op1 == kk) ? 2'd0 : sd);
    suf_sel = (o <= lim_val) ? suf_sv : 2'd0;
    suf_val = sat2(skip, suf_sel);
    tb_raw  = (rm1 == '0) ? 2'd1 : ((om1 == '0) ? 2'd0 : pd);
    tb_sel  = (om1 <= lim_val) ? tb_raw : 2'd0;
    take    = (tb_sel == 2'd1) && (tb_skip == 2'd0);
    c_pv    = (r == '0) ? 2'd1 : ((o == '0) ? 2'd0 : pd);
    c_sv    = (rp1 == ccount) ? 2'd1 : ((op1 == kk) ? 2'd0 : sd);
    hit     = (o <= lim_val) && (c_pv != 2'd0) && (c_sv != 2'd0);
    chain_n = chain && (feas == 2'd1);
  end

  // count tables
  always_ff @(posedge clk) begin
    if (state == S_FWR) ptab[{r, o}] <= fwd_val;
    if (state == S_SWR) stab[{r, o}] <= suf_val;
    pd <= ptab[p_raddr];
    sd <= stab[s_raddr];
  end

  // per-record limit and assignment stores
  always_ff @(posedge clk) begin
    if ((state == S_LIM && o == km1) ||
        (state == S_LIMC && !(vt_rdata <= ct_rdata))) begin
      lim[r[RIW-1:0]] <= o;
    end
    if (state == S_TRD3 && take) asg[rm1[RIW-1:0]] <= om1;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      r     <= '0;
      o     <= '0;
      kk    <= '0;
      skip  <= '0;
      cnt   <= '0;
      feas  <= '0;
      cons  <= '0;
      chain <= 1'b0;
      tb_skip <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) state <= S_CHECK;
        end
        S_CHECK: begin
          kk <= vcm1[OW-1:0];
          r  <= '0;
          o  <= '0;
          state <= bad_win ? S_BAD : S_LIM;
        end
        S_BAD: begin
          if (slot_free) state <= S_IDLE;
        end
        S_LIM: begin
          if (o == km1) begin
            if (rp1 == ccount) begin
              r <= CCW'(1);
              o <= OW'(1);
              skip <= '0;
              state <= S_FRD;
            end else begin
              r <= rp1;
            end
          end else begin
            state <= S_LIMC;
          end
        end
        S_LIMC: begin
          if (vt_rdata <= ct_rdata) begin
            o <= op1;
            state <= S_LIM;
          end else if (rp1 == ccount) begin
            r <= CCW'(1);
            o <= OW'(1);
            skip <= '0;
            state <= S_FRD;
          end else begin
            r <= rp1;
            state <= S_LIM;
          end
        end
        S_FRD: state <= S_FWR;
        S_FWR: begin
          if (o == kk) begin
            skip <= '0;
            if (r == ccount) begin
              cnt <= fwd_val;
              r <= rm1;
              o <= km1;
              state <= S_SRD;
            end else begin
              r <= rp1;
              o <= OW'(1);
              state <= S_FRD;
            end
          end else begin
            o <= op1;
            skip <= fwd_val;
            state <= S_FRD;
          end
        end
        S_SRD: state <= S_SWR;
        S_SWR: begin
          if (o == '0) begin
            skip <= '0;
            if (r == '0) begin
              if (cnt == CLS_UNIQUE) begin
                r <= ccount;
                o <= kk;
                state <= S_TRD1;
              end else begin
                o <= '0;
                feas <= '0;
                cons <= '0;
                chain <= 1'b1;
                state <= S_CRD;
              end
            end else begin
              r <= rm1;
              o <= km1;
              state <= S_SRD;
            end
          end else begin
            o <= om1;
            skip <= suf_val;
            state <= S_SRD;
          end
        end
        S_TRD1: state <= S_TRD2;
        S_TRD2: begin
          tb_skip <= (om1 == '0) ? 2'd0 : pd;
          state <= S_TRD3;
        end
        S_TRD3: begin
          if ((take && rm1 == '0) || om1 == '0) begin
            r <= '0;
            o <= '0;
            feas <= '0;
            cons <= '0;
            chain <= 1'b1;
            state <= S_CRD;
          end else begin
            o <= om1;
            if (take) r <= rm1;
            state <= S_TRD1;
          end
        end
        S_CRD: state <= S_CACC;
        S_CACC: begin
          if (hit) begin
            feas <= (feas == 2'd0) ? 2'd1 : 2'd2;
            cons <= o;
          end
          if (o == km1) begin
            state <= S_EMIT;
          end else begin
            o <= op1;
            state <= S_CRD;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            chain <= chain_n;
            if (rp1 == ccount) begin
              state <= S_IDLE;
            end else begin
              r <= rp1;
              o <= '0;
              feas <= '0;
              state <= S_CRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result item
  always_comb begin
    res = '0;
    emit = 1'b0;
    if (state == S_BAD) begin
      emit = slot_free;
      res.status = 1'b1;
      res.last = 1'b1;
    end else if (state == S_EMIT) begin
      emit = slot_free;
      res.sclass  = cnt;
      res.scount  = cnt;
      res.rec_idx = IDX_W'(r);
      res.cvalid  = chain_n;
      res.cord    = chain_n ? (info.first_ord + ORD_W'(cons)) : '0;
      res.avalid  = (cnt == CLS_UNIQUE);
      res.aord    = (cnt == CLS_UNIQUE) ?
                    (info.first_ord + ORD_W'(asg[r[RIW-1:0]])) : '0;
      res.last    = (rp1 == ccount);
    end
  end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the callback to vblank mapping solver core. Load
// windows of vblank samples and callback timestamps are built directed and at random with
// finishes spread among them. An in-bench window solver predicts every result
// item, and the monitor checks each field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import cbvb_pkg::*;

  localparam int NVB = 64;
  localparam int NREC = 32;
  localparam int QUIET_LIMIT = 200000;

  typedef struct {
    logic [1:0]        fn;
    logic [ORD_W-1:0]  ord;
    logic [TIME_W-1:0] t;
  } load_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        func = FN_NONE;
  logic [ORD_W-1:0]  event_ordinal = '0;
  logic [TIME_W-1:0] event_time = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              status;
  logic [1:0]        solution_class;
  logic [1:0]        solution_count;
  logic [IDX_W-1:0]  record_index;
  logic              consensus_valid;
  logic [ORD_W-1:0]  consensus_ordinal;
  logic              assigned_valid;
  logic [ORD_W-1:0]  assigned_ordinal;
  logic              last_result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;

  // pending items and expected result items
  load_item_t pend_q[$];
  result_t    expect_q[$];

  // shadow of the block's window
  logic [TIME_W-1:0] vb_time [NVB];
  logic [TIME_W-1:0] cb_time [NREC];
  logic [ORD_W-1:0]  base_ord = '0;
  int                vb_cnt = 0;
  int                cb_cnt = 0;
  bit                load_err = 1'b0;
  logic [CFG_W-1:0]  sync_reg = SYNC_ONE;
  logic [1:0]        fwd_tab [NREC+1][NVB+1];
  logic [1:0]        bwd_tab [NREC+1][NVB+1];

  int n_err = 0;
  int n_items = 0;
  int n_results = 0;
  int n_solved = 0;
  int idle_mode = 0;
  int hold_left = 0;
  int quiet = 0;

  // stimulus generator state
  logic [ORD_W-1:0]  gen_ord;
  logic [TIME_W-1:0] gen_time;
  int                gen_vb = 0;
  int                gen_cb = 0;
  bit                gen_after_vb = 1'b0;

  callback_to_vblank_mapping_solver_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .event_ordinal(event_ordinal), .event_time(event_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .solution_class(solution_class),
    .solution_count(solution_count), .record_index(record_index),
    .consensus_valid(consensus_valid), .consensus_ordinal(consensus_ordinal),
    .assigned_valid(assigned_valid), .assigned_ordinal(assigned_ordinal),
    .last_result(last_result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [1:0] cap_two(input int s);
    return (s > 2) ? 2'd2 : s[1:0];
  endfunction

  // single result item with only status and last set
  function automatic result_t flag_result(input bit st);
    result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // count maps of the current window and queue one result per record, or one error result
  task automatic solve_window();
    int r, o, rr, oo, nrec, nint, feas;
    logic [1:0] cnt, skip, sel;
    logic [ORD_W-1:0] cons;
    logic [ORD_W-1:0] asg [NREC];
    bit chain;
    result_t res;
    nrec = cb_cnt;
    if (load_err || sync_reg != SYNC_ONE || vb_cnt < 2 || nrec == 0) begin
      expect_q = {expect_q, flag_result(1'b1)};
      return;
    end
    nint = vb_cnt - 1;
    for (r = 0; r < nrec; r++) begin
      if (cb_time[r] < vb_time[0] || cb_time[r] >= vb_time[nint]) begin
        expect_q = {expect_q, flag_result(1'b1)};
        return;
      end
    end
    // forward counts
    for (o = 0; o <= nint; o++) fwd_tab[0][o] = 2'd1;
    for (r = 1; r <= nrec; r++) begin
      fwd_tab[r][0] = 2'd0;
      for (o = 1; o <= nint; o++) begin
        skip = fwd_tab[r][o-1];
        sel = (vb_time[o-1] <= cb_time[r-1]) ? fwd_tab[r-1][o-1] : 2'd0;
        fwd_tab[r][o] = cap_two(int'(skip) + int'(sel));
      end
    end
    cnt = fwd_tab[nrec][nint];
    // suffix counts
    for (o = 0; o <= nint; o++) bwd_tab[nrec][o] = 2'd1;
    for (r = nrec - 1; r >= 0; r--) begin
      bwd_tab[r][nint] = 2'd0;
      for (o = nint - 1; o >= 0; o--) begin
        skip = bwd_tab[r][o+1];
        sel = (vb_time[o] <= cb_time[r]) ? bwd_tab[r+1][o+1] : 2'd0;
        bwd_tab[r][o] = cap_two(int'(skip) + int'(sel));
      end
    end
    // traceback of a unique map
    for (r = 0; r < NREC; r++) asg[r] = '0;
    if (cnt == CLS_UNIQUE) begin
      rr = nrec;
      oo = nint;
      while (rr > 0 && oo > 0) begin
        skip = fwd_tab[rr][oo-1];
        sel = (vb_time[oo-1] <= cb_time[rr-1]) ? fwd_tab[rr-1][oo-1] : 2'd0;
        if (sel == 2'd1 && skip == 2'd0) begin
          asg[rr-1] = base_ord + (oo - 1);
          rr--;
        end
        oo--;
      end
    end
    // consensus prefix and per-record items
    chain = 1'b1;
    for (r = 0; r < nrec; r++) begin
      feas = 0;
      cons = '0;
      for (o = 0; o < nint; o++) begin
        if (vb_time[o] <= cb_time[r] && fwd_tab[r][o] != 2'd0 &&
            bwd_tab[r+1][o+1] != 2'd0) begin
          feas++;
          cons = base_ord + o;
        end
      end
      if (feas != 1) chain = 1'b0;
      res = '0;
      res.sclass = cnt;
      res.scount = cnt;
      res.rec_idx = r[IDX_W-1:0];
      res.cvalid = chain;
      res.cord = chain ? cons : '0;
      res.avalid = (cnt == CLS_UNIQUE);
      res.aord = (cnt == CLS_UNIQUE) ? asg[r] : '0;
      res.last = (r + 1 == nrec);
      expect_q = {expect_q, res};
    end
    n_solved++;
  endtask

  // update the shadow window for one accepted item
  task automatic apply_item(input logic [1:0] fn, input logic [ORD_W-1:0] ord,
                            input logic [TIME_W-1:0] t);
    logic [ORD_W-1:0] prev;
    if (fn == FN_FINISH) begin
      solve_window();
    end else if (fn == FN_NONE) begin
      expect_q = {expect_q, flag_result(1'b1)};
    end else begin
      if (!load_err) begin
        if (fn == FN_VBLANK) begin
          if (vb_cnt >= NVB) begin
            load_err = 1'b1;
          end else if (vb_cnt == 0) begin
            base_ord = ord;
            vb_time[0] = t;
            vb_cnt = 1;
          end else begin
            prev = base_ord + (vb_cnt - 1);
            if (prev == '1 || ord != prev + 1 || t <= vb_time[vb_cnt-1]) begin
              load_err = 1'b1;
            end else begin
              vb_time[vb_cnt] = t;
              vb_cnt++;
            end
          end
        end else begin
          if (cb_cnt >= NREC || (cb_cnt > 0 && t <= cb_time[cb_cnt-1])) begin
            load_err = 1'b1;
          end else begin
            cb_time[cb_cnt] = t;
            cb_cnt++;
          end
        end
      end
      expect_q = {expect_q, flag_result(load_err)};
    end
  endtask

  // driver: offers pending items, records accepted ones
  always @(posedge clk) begin
    int idle_pct;
    load_item_t it;
    idle_pct = (idle_mode == 0) ? 29 : (idle_mode == 1) ? 53 : 0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        apply_item(func, event_ordinal, event_time);
        n_items++;
      end
      if (!in_valid || !in_stall) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          it = pend_q.pop_front();
          in_valid <= 1'b1;
          func <= it.fn;
          event_ordinal <= it.ord;
          event_time <= it.t;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string nm, input logic [ORD_W-1:0] want,
                             input logic [ORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, want, got);
      n_err++;
    end
  endtask

  // monitor: stalls the output and checks each result item
  always @(posedge clk) begin
    int stall_pct;
    result_t want;
    stall_pct = (idle_mode == 0) ? 53 : (idle_mode == 1) ? 29 : 0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expect_q.size() == 0) begin
          $display("%0t: unexpected result item, record %0d", $time, record_index);
          n_err++;
        end else begin
          want = expect_q.pop_front();
          check_field("status", ORD_W'(want.status), ORD_W'(status));
          check_field("solution_class", ORD_W'(want.sclass), ORD_W'(solution_class));
          check_field("solution_count", ORD_W'(want.scount), ORD_W'(solution_count));
          check_field("record_index", ORD_W'(want.rec_idx), ORD_W'(record_index));
          check_field("consensus_valid", ORD_W'(want.cvalid), ORD_W'(consensus_valid));
          check_field("consensus_ordinal", want.cord, consensus_ordinal);
          check_field("assigned_valid", ORD_W'(want.avalid), ORD_W'(assigned_valid));
          check_field("assigned_ordinal", want.aord, assigned_ordinal);
          check_field("last_result", ORD_W'(want.last), ORD_W'(last_result));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] fn, input logic [ORD_W-1:0] ord,
                           input logic [TIME_W-1:0] t);
    load_item_t it;
    it.fn = fn;
    it.ord = ord;
    it.t = t;
    pend_q = {pend_q, it};
  endtask

  task automatic add_vblank(input int gap);
    gen_time = gen_time + gap;
    push_item(FN_VBLANK, gen_ord, gen_time);
    gen_ord++;
    gen_vb++;
    gen_after_vb = 1'b1;
  endtask

  // a zero gap is only legal right after a vblank
  task automatic add_callback(input int gap);
    if (gap == 0 && !gen_after_vb) gap = 1;
    gen_time = gen_time + gap;
    push_item(FN_CALLBACK, $urandom, gen_time);
    gen_cb++;
    gen_after_vb = 1'b0;
  endtask

  task automatic add_finish();
    push_item(FN_FINISH, $urandom, TIME_W'({$urandom, $urandom}));
  endtask

  task automatic wait_quiet();
    while (pend_q.size() > 0 || in_valid || expect_q.size() > 0) @(posedge clk);
  endtask

  task automatic write_sync(input logic [CFG_W-1:0] v);
    wait_quiet();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sync_reg = v;
  endtask

  // random window growth with finishes mixed in
  task automatic random_loads(input int n);
    int k, p;
    for (k = 0; k < n; k++) begin
      p = $urandom_range(99);
      if (p < 40 && gen_vb < 56)
        add_vblank($urandom_range(1, 40));
      else if (p < 72 && gen_cb < 28)
        add_callback($urandom_range(0, 25));
      else if (p < 94)
        add_finish();
      else
        push_item(FN_NONE, $urandom, TIME_W'({$urandom, $urandom}));
    end
  endtask

  initial begin
    int k;
    gen_ord = 32'hFFFF_FFC0;
    gen_time = 63'd100;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    write_sync(SYNC_ONE);

    // directed: empty finish, unknown func, short windows, edge of range
    add_finish();
    push_item(FN_NONE, '1, '1);
    add_vblank(0);
    add_callback(0);
    add_finish();
    add_vblank(10);
    add_finish();
    add_callback(15);
    add_finish();
    add_vblank(3);
    add_finish();
    add_vblank(4);
    add_vblank(4);
    add_finish();
    add_callback(1);
    add_callback(1);
    add_vblank(2);
    add_finish();
    random_loads(70);

    // odd sync settings make every finish invalid
    write_sync(4'd0);
    add_finish();
    write_sync(4'hF);
    add_finish();
    write_sync(SYNC_ONE);

    idle_mode = 1;
    random_loads(70);

    // no idling, long output hold-off while items keep coming
    wait_quiet();
    idle_mode = 2;
    hold_left = 400;
    while (gen_cb < NREC) add_callback($urandom_range(0, 5));
    while (gen_vb < NVB) add_vblank($urandom_range(1, 30));
    add_finish();
    // overflow, sticky error, bad ordering, noise
    add_callback(1);
    add_vblank(1);
    add_finish();
    push_item(FN_VBLANK, '0, '1);
    push_item(FN_NONE, '0, '0);
    for (k = 0; k < 8; k++)
      push_item(2'($urandom_range(0, 3)), $urandom, TIME_W'({$urandom, $urandom}));

    wait_quiet();
    repeat (50) @(posedge clk);
    $display("ran %0d input items and %0d result items", n_items, n_results);
    $display("solved %0d windows, up to a full store of vblanks and callbacks",
             n_solved);
    if (n_err == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
